>>> rtl/core/tpe_pkg.sv
// shared constants, types and elaboration-time table functions for the tropopause estimator
`default_nettype none

package tpe_pkg;

    localparam int TPE_STAGES    = 9;
    localparam int TPE_POW_DEPTH = 256;

    localparam int TPE_LAT_W = 15;
    localparam int TPE_PA_W  = 17;
    localparam int TPE_DOY_W = 9;
    localparam int TPE_EST_W = 18;
    localparam int TPE_IDX_W = 4;

    // register indexes
    localparam logic [TPE_IDX_W-1:0] TPE_REG_EQUATOR = 4'd0;
    localparam logic [TPE_IDX_W-1:0] TPE_REG_POLE    = 4'd1;
    localparam logic [TPE_IDX_W-1:0] TPE_REG_DAY     = 4'd2;
    localparam logic [TPE_IDX_W-1:0] TPE_REG_MODE    = 4'd3;

    localparam logic [TPE_PA_W-1:0]  TPE_EQUATOR_RST = 17'd9500;
    localparam logic [TPE_PA_W-1:0]  TPE_POLE_RST    = 17'd26000;
    localparam logic [TPE_DOY_W-1:0] TPE_DAY_RST     = 9'd0;

    // floor(2^44 / 1875): reciprocal for the ramp divide by 7500 with 2^16 scale
    localparam logic [33:0] TPE_RECIP_K = 34'd9382499223;
    localparam logic [10:0] TPE_DIV_C   = 11'd1875;

    localparam logic [63:0] TPE_PI_Q30  = 64'd3373259426;
    localparam logic [63:0] TPE_LN2_Q32 = 64'd2977044472;
    localparam logic [63:0] TPE_HSCALE  = 64'd2903748903;
    localparam logic [63:0] TPE_ONE_Q32 = 64'd4294967296;

    typedef struct packed {
        logic [TPE_STAGES-1:0] en;
        logic [TPE_STAGES-1:0] vld;
    } tpe_pipe_ctrl_t;

    function automatic longint tpe_log2_q32(input logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e    = 0;
        frac = 64'd0;
        for (int i = 1; i < 64; i++) begin
            if (v[i]) e = i;
        end
        if (e > 31) m = v >> (e - 31);
        else m = v << (31 - e);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            if (m >= TPE_ONE_Q32) begin
                m = m >> 1;
                frac = frac | (64'd1 << (31 - i));
            end
        end
        return longint'(e - 32) * longint'(TPE_ONE_Q32) + longint'(frac);
    endfunction

    function automatic logic [63:0] tpe_exp2_q32(input longint t);
        longint      n;
        logic [63:0] f;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        n    = t >>> 32;
        f    = {32'd0, t[31:0]};
        z    = (f * TPE_LN2_Q32) >> 32;
        term = TPE_ONE_Q32;
        sum  = term;
        for (int i = 1; i <= 13; i++) begin
            term = ((term * z) >> 32) / 64'(i);
            sum  = sum + term;
        end
        if (n >= 0) return (n < 8) ? (sum << n) : {64{1'b1}};
        if (n <= -40) return 64'd0;
        return sum >> (-n);
    endfunction

    // height in q16 metres for a q32 pressure ratio x of a table point
    function automatic longint tpe_height_q16(input logic [63:0] x);
        logic [63:0] y;
        logic [63:0] mag;
        longint      h;
        y = 64'd0;
        if (x != 64'd0) y = tpe_exp2_q32(tpe_log2_q32(x) * 19 / 100);
        mag = (y <= TPE_ONE_Q32) ? (TPE_ONE_Q32 - y) : (y - TPE_ONE_Q32);
        h   = longint'((TPE_HSCALE * (mag >> 8)) >> 24);
        return (y <= TPE_ONE_Q32) ? h : -h;
    endfunction

    // seasonal term in q16 pascals for a half-degree angle of 0..180
    function automatic logic [63:0] tpe_season_q16(input logic [63:0] a);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        longint      sum;
        th   = a * TPE_PI_Q30 / 64'd360;
        th2  = (th * th) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
        return (64'(sum) * 64'd5000) >> 14;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tpe_pipe_ctrl.sv
// valid and stall control for the stages of the estimator pipeline
`default_nettype none

module tpe_pipe_ctrl
    import tpe_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           out_ready,
    output tpe_pipe_ctrl_t      ctrl
);

    logic [TPE_STAGES-1:0] vld_reg;
    logic [TPE_STAGES-1:0] vld_next;
    logic [TPE_STAGES-1:0] en;

    // a stage loads when empty or when the stage after it moves on
    always_comb begin
        en[TPE_STAGES-1] = !vld_reg[TPE_STAGES-1] || out_ready;
        for (int i = TPE_STAGES - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (en[0]) vld_next[0] = in_valid;
        for (int i = 1; i < TPE_STAGES; i++) begin
            if (en[i]) vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready = en[0];
    assign ctrl.en  = en;
    assign ctrl.vld = vld_reg;

endmodule

`default_nettype wire

>>> rtl/core/tropopause_pressure_estimate.sv
// top level of the tropopause pressure and height estimator
//
// usage
//   one latitude item (s_latitude_centideg, hundredths of a degree) enters on
//   s_valid/s_ready, one estimate item (m_estimate) leaves on m_valid/m_ready
//   registers are written through cfg_valid/cfg_ready with cfg_index and cfg_data:
//   0 equator pressure, 1 pole pressure, 2 day of year, 3 height mode
//   other indexes are ignored; cfg_ready is always high
//   the path from the accepting edge to m_valid runs through nine register stages,
//   the first loaded at the accepting edge itself
//   throughput is one item per cycle while m_ready is high; every stage hands its
//   item on in each cycle that the stage after it moves (input register, ramp
//   multiply, reciprocal multiply, remainder correction, season add, lookup
//   scale, table read, interpolation multiply, round and saturate)
//   reset empties the pipeline and loads 9500 Pa, 26000 Pa, day 0, pascal mode
//   when the receiver stalls, items pack into empty stages and then the whole
//   pipeline holds; s_ready drops only once every stage is full
//   the pressure and height tables are constants built at elaboration
`default_nettype none

module tropopause_pressure_estimate
    import tpe_pkg::*;
#(
    parameter int POW_TABLE_DEPTH = TPE_POW_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [TPE_LAT_W-1:0] s_latitude_centideg,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [TPE_EST_W-1:0]      m_estimate,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [TPE_IDX_W-1:0]        cfg_index,
    input  wire logic [TPE_PA_W-1:0]         cfg_data
);

    // index width covers table points 0..POW_TABLE_DEPTH
    localparam int IW = $clog2(POW_TABLE_DEPTH + 1);
    localparam int SW = IW + 18;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [TPE_PA_W-1:0]  eq_pa_reg;
    logic [TPE_PA_W-1:0]  pole_pa_reg;
    logic [TPE_DOY_W-1:0] doy_reg;
    logic                 mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eq_pa_reg   <= TPE_EQUATOR_RST;
            pole_pa_reg <= TPE_POLE_RST;
            doy_reg     <= TPE_DAY_RST;
            mode_reg    <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                TPE_REG_EQUATOR: eq_pa_reg   <= cfg_data;
                TPE_REG_POLE:    pole_pa_reg <= cfg_data;
                TPE_REG_DAY:     doy_reg     <= cfg_data[TPE_DOY_W-1:0];
                TPE_REG_MODE:    mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // constant tables
    // ---------------------------------------------------------------
    logic [28:0]        seas_tab [0:180];
    logic signed [33:0] hgt_tab  [0:POW_TABLE_DEPTH];

    for (genvar g = 0; g <= 180; g++) begin : g_seas
        localparam logic [63:0] SV = tpe_season_q16(64'(g));
        assign seas_tab[g] = SV[28:0];
    end

    // table point g sits at g*2^18/POW_TABLE_DEPTH Pa, ratio to 101325 Pa in q32
    for (genvar g = 0; g <= POW_TABLE_DEPTH; g++) begin : g_hgt
        localparam logic [63:0] HX = (64'(g) << 50) / (64'(POW_TABLE_DEPTH) * 64'd101325);
        localparam longint HV = tpe_height_q16(HX);
        assign hgt_tab[g] = 34'(HV);
    end

    // ---------------------------------------------------------------
    // pipeline control
    // ---------------------------------------------------------------
    tpe_pipe_ctrl_t ctrl;

    tpe_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_ready (m_ready),
        .ctrl      (ctrl)
    );

    // stage 1: input register
    logic signed [TPE_LAT_W-1:0] lat1_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) lat1_reg <= s_latitude_centideg;
    end

    // stage 2: ramp fraction, ramp product, season lookup
    logic signed [15:0] lat_x;
    logic [15:0]        alat;
    logic [12:0]        t_val;
    logic               north;
    logic signed [10:0] ddiff;
    logic [9:0]         a_raw;
    logic [9:0]         a_fold;
    logic [7:0]         a_idx;
    logic               neg_cos;
    logic signed [17:0] dd;
    logic [16:0]        dmag;
    logic [29:0]        p_next;
    logic signed [29:0] seas_next;

    always_comb begin
        lat_x = {lat1_reg[TPE_LAT_W-1], lat1_reg};
        alat  = lat_x[15] ? 16'(-lat_x) : 16'(lat_x);
        if (alat <= 16'd1500) t_val = 13'd0;
        else if (alat >= 16'd9000) t_val = 13'd7500;
        else t_val = 13'(alat - 16'd1500);

        // zero latitude counts as southern
        north = !lat_x[15] && (lat_x != 16'sd0);
        ddiff = $signed({2'b00, doy_reg}) - (north ? 11'sd203 : 11'sd21);
        a_raw = ddiff[10] ? 10'(-ddiff) : 10'(ddiff);
        a_fold = (a_raw > 10'd360) ? 10'd720 - a_raw : a_raw;
        if (a_fold > 10'd180) begin
            a_idx   = 8'(10'd360 - a_fold);
            neg_cos = 1'b1;
        end else begin
            a_idx   = a_fold[7:0];
            neg_cos = 1'b0;
        end
        seas_next = neg_cos ? -$signed({1'b0, seas_tab[a_idx]})
                            : $signed({1'b0, seas_tab[a_idx]});

        dd     = $signed({1'b0, pole_pa_reg}) - $signed({1'b0, eq_pa_reg});
        dmag   = dd[17] ? 17'(-dd) : 17'(dd);
        p_next = 30'(dmag) * 30'(t_val);
    end

    logic [29:0]        p2_reg;
    logic               dneg2_reg;
    logic signed [29:0] seas2_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[1]) begin
            p2_reg    <= p_next;
            dneg2_reg <= dd[17];
            seas2_reg <= seas_next;
        end
    end

    // stage 3: reciprocal multiply, quotient low by at most one
    logic [63:0] rprod;
    logic [33:0] qe_next;

    assign rprod   = 64'(p2_reg) * 64'(TPE_RECIP_K);
    assign qe_next = rprod[63:30];

    logic [29:0]        p3_reg;
    logic [33:0]        qe3_reg;
    logic               dneg3_reg;
    logic signed [29:0] seas3_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[2]) begin
            p3_reg    <= p2_reg;
            qe3_reg   <= qe_next;
            dneg3_reg <= dneg2_reg;
            seas3_reg <= seas2_reg;
        end
    end

    // stage 4: remainder correction and ramp start in q16
    logic [47:0]        rem;
    logic [33:0]        q_fix;
    logic signed [35:0] eq_q16;
    logic signed [35:0] q_s;
    logic signed [35:0] start_next;

    always_comb begin
        rem   = 48'({p3_reg, 14'd0}) - 48'(qe3_reg) * 48'(TPE_DIV_C);
        q_fix = (rem >= 48'(TPE_DIV_C)) ? qe3_reg + 34'd1 : qe3_reg;
        eq_q16 = $signed({3'b000, eq_pa_reg, 16'd0});
        q_s    = $signed({2'b00, q_fix});
        start_next = dneg3_reg ? eq_q16 - q_s : eq_q16 + q_s;
    end

    logic signed [35:0] start4_reg;
    logic signed [29:0] seas4_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[3]) begin
            start4_reg <= start_next;
            seas4_reg  <= seas3_reg;
        end
    end

    // stage 5: add seasonal term
    logic signed [35:0] pq_next;

    assign pq_next = start4_reg + 36'(seas4_reg);

    logic signed [35:0] pq5_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[4]) pq5_reg <= pq_next;
    end

    // stage 6: pascal rounding and table position
    logic signed [35:0] pr;
    logic signed [19:0] est_pa_next;
    logic signed [19:0] pa_w;
    logic [17:0]        pa_c;
    logic [SW-1:0]      s_next;

    always_comb begin
        pr          = pq5_reg + 36'sd32768;
        est_pa_next = pr[35:16];
        pa_w        = pq5_reg[35:16];
        if (pa_w[19]) pa_c = 18'd0;
        else if (pa_w > 20'sd262143) pa_c = 18'd262143;
        else pa_c = pa_w[17:0];
        s_next = SW'(pa_c) * SW'(POW_TABLE_DEPTH);
    end

    logic signed [19:0] est6_reg;
    logic [SW-1:0]      s6_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[5]) begin
            est6_reg <= est_pa_next;
            s6_reg   <= s_next;
        end
    end

    // stage 7: table read at two neighboring points
    logic [IW-1:0] idx0;
    logic [IW-1:0] idx1;

    assign idx0 = s6_reg[SW-1:18];
    assign idx1 = idx0 + IW'(1);

    logic signed [33:0] e0_7_reg;
    logic signed [33:0] e1_7_reg;
    logic [17:0]        frac7_reg;
    logic signed [19:0] est7_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[6]) begin
            e0_7_reg  <= hgt_tab[idx0];
            e1_7_reg  <= hgt_tab[idx1];
            frac7_reg <= s6_reg[17:0];
            est7_reg  <= est6_reg;
        end
    end

    // stage 8: interpolation multiply
    logic signed [34:0] edif;
    logic signed [53:0] iprod_next;

    assign edif       = 35'(e1_7_reg) - 35'(e0_7_reg);
    assign iprod_next = edif * $signed({1'b0, frac7_reg});

    logic signed [53:0] iprod8_reg;
    logic signed [33:0] e0_8_reg;
    logic signed [19:0] est8_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[7]) begin
            iprod8_reg <= iprod_next;
            e0_8_reg   <= e0_7_reg;
            est8_reg   <= est7_reg;
        end
    end

    // stage 9: truncate toward zero, round, select mode, saturate
    logic signed [53:0]        ibias;
    logic signed [35:0]        itrunc;
    logic signed [36:0]        hq;
    logic signed [36:0]        hr;
    logic signed [20:0]        est_sel;
    logic signed [TPE_EST_W-1:0] est_next;

    always_comb begin
        ibias  = iprod8_reg[53] ? iprod8_reg + 54'sd262143 : iprod8_reg;
        itrunc = ibias[53:18];
        hq     = 37'(e0_8_reg) + 37'(itrunc);
        hr     = hq + 37'sd32768;
        est_sel = mode_reg ? hr[36:16] : 21'(est8_reg);
        if (est_sel < -21'sd1000) est_next = -18'sd1000;
        else if (est_sel > 21'sd131071) est_next = 18'sd131071;
        else est_next = est_sel[TPE_EST_W-1:0];
    end

    logic signed [TPE_EST_W-1:0] est9_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en[8]) est9_reg <= est_next;
    end

    assign m_valid    = ctrl.vld[TPE_STAGES-1];
    assign m_estimate = est9_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the tropopause pressure and height estimator
`default_nettype none

module tb;
    import tpe_pkg::*;

    localparam int TABLE_N   = 256;
    localparam int LAT_ITEMS = 1750;
    localparam int MAX_CYC   = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [TPE_LAT_W-1:0] s_latitude_centideg = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [TPE_EST_W-1:0] m_estimate;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [TPE_IDX_W-1:0]        cfg_index = '0;
    logic [TPE_PA_W-1:0]         cfg_data = '0;

    tropopause_pressure_estimate i_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_latitude_centideg,
        .m_valid, .m_ready, .m_estimate,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always #5 aclk = ~aclk;

    // register shadow, follows every accepted write
    logic [TPE_PA_W-1:0]  equator_pa = TPE_EQUATOR_RST;
    logic [TPE_PA_W-1:0]  pole_pa    = TPE_POLE_RST;
    logic [TPE_DOY_W-1:0] doy        = TPE_DAY_RST;
    logic                 to_height  = 1'b0;

    longint height_tbl [0:TABLE_N];
    logic signed [TPE_EST_W-1:0] estimate_q [$];

    int  errors = 0;
    int  n_results = 0;
    int  n_height = 0;
    int  n_sat = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  typed_on = 1'b0;
    logic signed [TPE_EST_W-1:0] typed_val = '0;

    function automatic longint fdiv(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint log2_fix(input logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [63:0] fr;
        e  = 0;
        fr = 0;
        for (int i = 63; i > 0; i--) begin
            if (v[i] && e == 0) e = i;
        end
        m = (e > 31) ? (v >> (e - 31)) : (v << (31 - e));
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m  = m >> 1;
                fr = fr | (64'd1 << (31 - i));
            end
        end
        return longint'(e - 32) * 64'sh1_0000_0000 + longint'(fr);
    endfunction

    function automatic logic [63:0] exp2_fix(input longint t);
        longint      n;
        logic [63:0] f;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        n    = t >>> 32;
        f    = 64'(t - (n <<< 32));
        z    = (f * 64'd2977044472) >> 32;
        term = 64'h1_0000_0000;
        sum  = term;
        for (int i = 1; i <= 13; i++) begin
            term = ((term * z) >> 32) / 64'(i);
            sum  = sum + term;
        end
        if (n >= 0) return (n < 8) ? (sum << n) : {64{1'b1}};
        if (n <= -40) return 64'd0;
        return sum >> (-n);
    endfunction

    // height in q16 metres at table point k
    function automatic longint height_at(input int k);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] mag;
        longint      h;
        x = (64'(k) << 50) / (64'(TABLE_N) * 64'd101325);
        y = 0;
        if (x != 0) y = exp2_fix(log2_fix(x) * 19 / 100);
        mag = (y <= 64'h1_0000_0000) ? (64'h1_0000_0000 - y) : (y - 64'h1_0000_0000);
        h   = longint'((64'd2903748903 * (mag >> 8)) >> 24);
        return (y <= 64'h1_0000_0000) ? h : -h;
    endfunction

    // cosine in q30 of a half-degree angle
    function automatic longint cos_half_deg(input longint a);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        longint      sum;
        th   = 64'(a) * 64'd3373259426 / 64'd360;
        th2  = (th * th) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
        return sum;
    endfunction

    function automatic logic signed [TPE_EST_W-1:0] estimate_of(
        input logic signed [TPE_LAT_W-1:0] lat_in);
        longint lat, alat, t, d, start, diff, a, season, p, est, pa, s, idx, fr, h;
        bit     neg;
        lat  = longint'(lat_in);
        alat = (lat < 0) ? -lat : lat;
        t    = alat - 1500;
        if (t < 0) t = 0;
        if (t > 7500) t = 7500;
        d     = longint'(pole_pa) - longint'(equator_pa);
        start = longint'(equator_pa) * 65536 + d * t * 65536 / 7500;
        // northern items peak at day 203, zero and southern at day 21
        diff = longint'(doy) - ((lat > 0) ? 203 : 21);
        a    = (diff < 0) ? -diff : diff;
        neg  = 1'b0;
        if (a > 360) a = 720 - a;
        if (a > 180) begin
            a   = 360 - a;
            neg = 1'b1;
        end
        season = longint'((64'(cos_half_deg(a)) * 64'd5000) >> 14);
        p      = neg ? start - season : start + season;
        if (to_height) begin
            pa = fdiv(p, 65536);
            if (pa < 0) pa = 0;
            if (pa > 262143) pa = 262143;
            s   = pa * TABLE_N;
            idx = s >>> 18;
            fr  = s & 262143;
            h   = height_tbl[idx] + (height_tbl[idx + 1] - height_tbl[idx]) * fr / 262144;
            est = fdiv(h + 32768, 65536);
        end else begin
            est = fdiv(p + 32768, 65536);
        end
        if (est < -1000) est = -1000;
        if (est > 131071) est = 131071;
        return TPE_EST_W'(est);
    endfunction

    // accept, predict and compare at the rising edge
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    TPE_REG_EQUATOR: equator_pa = cfg_data;
                    TPE_REG_POLE:    pole_pa = cfg_data;
                    TPE_REG_DAY:     doy = cfg_data[TPE_DOY_W-1:0];
                    TPE_REG_MODE:    to_height = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                estimate_q.push_back(typed_on ? typed_val : estimate_of(s_latitude_centideg));
                if (to_height) n_height++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (m_estimate == -1000 || m_estimate == 131071) n_sat++;
                if (estimate_q.size() == 0) begin
                    $display("%0t: estimate item with none expected, actual %0d",
                             $time, m_estimate);
                    errors++;
                end else begin
                    if (m_estimate !== estimate_q[0]) begin
                        $display("%0t: estimate expected %0d actual %0d",
                                 $time, estimate_q[0], m_estimate);
                        errors++;
                    end
                    void'(estimate_q.pop_front());
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    int hold_left = 0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold_left     <= 80;
            m_ready       <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(0, 3);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycles >= MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_lat(input logic signed [TPE_LAT_W-1:0] lat);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_latitude_centideg <= lat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_valid  <= 1'b0;
        typed_on = 1'b0;
    endtask

    // registers change only once the pipeline has emptied
    task automatic write_reg(input logic [TPE_IDX_W-1:0] idx, input logic [TPE_PA_W-1:0] val);
        stop_sending();
        wait (estimate_q.size() == 0);
        repeat (TPE_STAGES + 3) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [TPE_PA_W-1:0] eq, input logic [TPE_PA_W-1:0] po,
                             input logic [TPE_DOY_W-1:0] dy, input logic md);
        write_reg(TPE_REG_EQUATOR, eq);
        write_reg(TPE_REG_POLE, po);
        write_reg(TPE_REG_DAY, TPE_PA_W'(dy));
        write_reg(TPE_REG_MODE, TPE_PA_W'(md));
    endtask

    function automatic logic [TPE_PA_W-1:0] rand_pa();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return TPE_PA_W'($urandom);
            default: return TPE_PA_W'($urandom_range(1000, 100000));
        endcase
    endfunction

    function automatic logic signed [TPE_LAT_W-1:0] rand_lat();
        case ($urandom_range(0, 9))
            0:       return TPE_LAT_W'($urandom);
            1:       return TPE_LAT_W'($urandom_range(0, 3000)) - 15'sd1500;
            default: return TPE_LAT_W'(int'($urandom_range(0, 18000)) - 9000);
        endcase
    endfunction

    typedef struct {
        bit                          new_cfg;
        logic [TPE_PA_W-1:0]         eq;
        logic [TPE_PA_W-1:0]         po;
        logic [TPE_DOY_W-1:0]        dy;
        logic                        md;
        logic signed [TPE_LAT_W-1:0] lat;
        bit                          typed;
        int                          est;
    } lat_row_t;

    // directed rows: reset settings, saturation both ways, clamped lookup, fields at extremes
    lat_row_t rows [] = '{
        '{0, 0, 0, 0, 0, 15'sd0, 0, 0},
        '{0, 0, 0, 0, 0, 15'sd9000, 0, 0},
        '{0, 0, 0, 0, 0, -15'sd9000, 0, 0},
        '{0, 0, 0, 0, 0, 15'sd1500, 0, 0},
        '{0, 0, 0, 0, 0, 15'sd16383, 0, 0},
        '{0, 0, 0, 0, 0, -15'sd16384, 0, 0},
        '{1, 131071, 131071, 203, 0, 15'sd9000, 1, 131071},
        '{0, 0, 0, 0, 0, -15'sd9000, 0, 0},
        '{0, 0, 0, 0, 0, 15'sd0, 0, 0},
        '{1, 131071, 131071, 203, 1, 15'sd9000, 1, -1000},
        '{1, 0, 0, 381, 1, 15'sd0, 1, 44308},
        '{1, 0, 0, 381, 0, 15'sd0, 1, -1000},
        '{1, 100000, 1000, 511, 0, 15'sd4000, 0, 0},
        '{0, 0, 0, 0, 0, -15'sd4000, 0, 0},
        '{1, 1000, 100000, 182, 1, 15'sd8999, 0, 0},
        '{0, 0, 0, 0, 0, -15'sd1, 0, 0},
        '{0, 0, 0, 0, 0, 15'sd1, 0, 0},
        '{1, 9500, 26000, 365, 1, 15'sd4500, 0, 0}
    };

    initial begin
        int sent;
        for (int k = 0; k <= TABLE_N; k++) height_tbl[k] = height_at(k);
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[r]) begin
            if (rows[r].new_cfg) write_all(rows[r].eq, rows[r].po, rows[r].dy, rows[r].md);
            typed_on  = rows[r].typed;
            typed_val = TPE_EST_W'(rows[r].est);
            send_lat(rows[r].lat);
            typed_on = 1'b0;
        end

        // random phases, each with its own settings
        sent = 0;
        for (int ph = 0; sent < LAT_ITEMS; ph++) begin
            write_all(rand_pa(), rand_pa(), TPE_DOY_W'($urandom), 1'($urandom));
            if ($urandom_range(0, 2) == 0)
                write_reg(TPE_IDX_W'($urandom_range(4, 15)), TPE_PA_W'($urandom));
            if (ph == 1) long_hold_req = 1'b1;
            if (sent >= LAT_ITEMS - 200) quiet = 1'b1;
            for (int i = 0; i < 150 && sent < LAT_ITEMS; i++) begin
                send_lat(rand_lat());
                sent++;
            end
        end
        stop_sending();

        wait (estimate_q.size() == 0);
        repeat (TPE_STAGES + 10) @(negedge aclk);
        $display("%0d estimates checked, %0d in height mode, %0d saturated",
                 n_results, n_height, n_sat);
        $display("settings swept per phase, register extremes and ignored indexes included");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/tpe_pkg.sv
rtl/core/tpe_pipe_ctrl.sv
rtl/core/tropopause_pressure_estimate.sv
tb/tb.sv
